[src/ffha_pkg.sv]
// Shared types and codes for the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_SIZE_ZERO = 2'd2;
    localparam logic [1:0] ST_NO_MEMORY = 2'd3;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_size;
        logic [14:0] free_address;
        logic        free_is_null;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] data_address;
    } t_res;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic valid;
        t_res res;
    } t_done;

endpackage
`default_nettype wire

[src/ffha_hdr_mem.sv]
// Header store: one-port-write, one-port-read synchronous memory.
`default_nettype none
module ffha_hdr_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int DW    = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule
`default_nettype wire

[src/ffha_ctrl.sv]
// Allocation and free sequencer: walks, splits and merges headers in the store.
`default_nettype none
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int PAGE_BYTES   = 4096,
    parameter int NUM_PAGES    = 8,
    parameter int HEADER_BYTES = 32,
    parameter int GW           = 12,
    parameter int SZW          = 9,
    parameter int EW           = 20
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req_valid,
    input  wire t_req           i_req,
    output logic                o_req_stall,
    output t_done               o_done,
    input  wire logic           i_done_ready,
    output logic                o_mem_we,
    output logic      [GW-1:0]  o_mem_waddr,
    output logic      [EW-1:0]  o_mem_wdata,
    output logic                o_mem_re,
    output logic      [GW-1:0]  o_mem_raddr,
    input  wire logic [EW-1:0]  i_mem_rdata
);

    localparam int PG   = PAGE_BYTES / 8;
    localparam int HG   = HEADER_BYTES / 8;
    localparam int LIM  = PG - HG;
    localparam int POOL = NUM_PAGES * PAGE_BYTES;
    localparam int PCW  = $clog2(NUM_PAGES + 1);
    localparam int OW   = SZW + 2;

    localparam logic [OW-1:0]  HG_W  = OW'(HG);
    localparam logic [OW-1:0]  PG_W  = OW'(PG);
    localparam logic [SZW-1:0] LIM_W = SZW'(LIM);

    // sequencer states
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ARD   = 5'd1;
    localparam logic [4:0] S_ACHK  = 5'd2;
    localparam logic [4:0] S_NOFIT = 5'd3;
    localparam logic [4:0] S_TAKE  = 5'd4;
    localparam logic [4:0] S_TCUR  = 5'd5;
    localparam logic [4:0] S_FIXRD = 5'd6;
    localparam logic [4:0] S_FIXWR = 5'd7;
    localparam logic [4:0] S_FCHK  = 5'd8;
    localparam logic [4:0] S_FOFF  = 5'd9;
    localparam logic [4:0] S_FRD   = 5'd10;
    localparam logic [4:0] S_FCUR  = 5'd11;
    localparam logic [4:0] S_FPRV  = 5'd12;
    localparam logic [4:0] S_FNX   = 5'd13;
    localparam logic [4:0] S_FNCHK = 5'd14;
    localparam logic [4:0] S_FEND  = 5'd15;
    localparam logic [4:0] S_DONE  = 5'd16;

    logic [4:0]     r_state, n_state, r_ret, n_ret;
    logic [PCW-1:0] r_pages, n_pages, r_pg, n_pg;
    logic [SZW-1:0] r_off, n_off, r_rg, n_rg, r_noff, n_noff;
    logic [SZW-1:0] r_fix_off, n_fix_off, r_fix_prev, n_fix_prev;
    logic           r_fix_en, n_fix_en;
    logic           r_cv, n_cv, r_cu, n_cu;
    logic [SZW-1:0] r_cs, n_cs, r_cp, n_cp;
    logic [14:0]    r_fa, n_fa;
    logic [GW-1:0]  r_g, n_g;
    logic [1:0]     r_st, n_st;
    logic [14:0]    r_addr, n_addr;

    // fields of the header just read
    logic           m_v, m_u;
    logic [SZW-1:0] m_s, m_p;
    assign m_v = i_mem_rdata[EW-1];
    assign m_u = i_mem_rdata[EW-2];
    assign m_s = i_mem_rdata[2*SZW-1:SZW];
    assign m_p = i_mem_rdata[SZW-1:0];

    // granule address of an offset in the current page
    function automatic logic [GW-1:0] gaddr(input logic [PCW-1:0] pg,
                                            input logic [SZW-1:0] off);
        logic [31:0] t;
        t = 32'(pg) * 32'(PG) + 32'(off);
        return t[GW-1:0];
    endfunction

    // rounded request in granules
    logic [16:0] req_sum;
    logic [13:0] rg14;
    assign req_sum = {1'b0, i_req.request_size} + 17'd7;
    assign rg14    = req_sum[16:3];

    // offset of the following entry, for the current entry and the one read
    logic [OW-1:0] cur_next, rd_next, split_off;
    assign cur_next  = {2'b00, r_off} + HG_W + {2'b00, r_cs};
    assign rd_next   = {2'b00, r_noff} + HG_W + {2'b00, m_s};
    assign split_off = {2'b00, r_off} + HG_W + {2'b00, r_rg};

    // free address decode: data offset, granule and page by threshold count
    logic [31:0]    fa_rel;
    logic [PCW-1:0] fa_page;
    always_comb begin
        fa_rel  = 32'(r_fa) - 32'(HEADER_BYTES);
        fa_page = '0;
        for (int k = 1; k < NUM_PAGES; k++) begin
            fa_page = fa_page + PCW'((fa_rel >> 3) >= 32'(k * PG));
        end
    end

    logic [31:0] byte_addr;
    assign byte_addr = 32'(gaddr(r_pg, r_off)) * 32'd8 + 32'(HEADER_BYTES);

    assign o_req_stall = (r_state != S_IDLE);

    // next-state and memory access logic
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_pages    = r_pages;
        n_pg       = r_pg;
        n_off      = r_off;
        n_rg       = r_rg;
        n_noff     = r_noff;
        n_fix_off  = r_fix_off;
        n_fix_prev = r_fix_prev;
        n_fix_en   = r_fix_en;
        n_cv       = r_cv;
        n_cu       = r_cu;
        n_cs       = r_cs;
        n_cp       = r_cp;
        n_fa       = r_fa;
        n_g        = r_g;
        n_st       = r_st;
        n_addr     = r_addr;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_waddr = gaddr(r_pg, r_off);
        o_mem_raddr = gaddr(r_pg, r_off);
        o_mem_wdata = {r_cv, r_cu, r_cs, r_cp};
        o_done.valid = 1'b0;
        o_done.res.status       = r_st;
        o_done.res.data_address = r_addr;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_st   = ST_OK;
                    n_addr = '0;
                    if (i_req.kind == KIND_ALLOC) begin
                        if (32'(rg14) > 32'(LIM)) begin
                            n_st    = ST_TOO_LARGE;
                            n_state = S_DONE;
                        end else if (rg14 == 14'd0) begin
                            n_st    = ST_SIZE_ZERO;
                            n_state = S_DONE;
                        end else begin
                            n_rg = SZW'(rg14);
                            n_pg  = '0;
                            n_off = '0;
                            n_state = (r_pages == '0) ? S_NOFIT : S_ARD;
                        end
                    end else if (i_req.free_is_null) begin
                        n_state = S_DONE;
                    end else begin
                        n_fa    = i_req.free_address;
                        n_state = S_FCHK;
                    end
                end
            end
            // first-fit walk
            S_ARD: begin
                o_mem_re = 1'b1;
                n_state  = S_ACHK;
            end
            S_ACHK: begin
                if (!m_u && m_s >= r_rg) begin
                    n_cv = m_v;
                    n_cu = m_u;
                    n_cs = m_s;
                    n_cp = m_p;
                    n_state = S_TAKE;
                end else if ((({2'b00, r_off} + HG_W + {2'b00, m_s})) < PG_W) begin
                    n_off   = SZW'({2'b00, r_off} + HG_W + {2'b00, m_s});
                    n_state = S_ARD;
                end else if (32'(r_pg) + 32'd1 < 32'(r_pages)) begin
                    n_pg    = r_pg + PCW'(1);
                    n_off   = '0;
                    n_state = S_ARD;
                end else begin
                    n_state = S_NOFIT;
                end
            end
            S_NOFIT: begin
                if (32'(r_pages) < 32'(NUM_PAGES)) begin
                    n_pg    = r_pages;
                    n_off   = '0;
                    n_cv    = 1'b1;
                    n_cu    = 1'b0;
                    n_cs    = LIM_W;
                    n_cp    = '0;
                    n_pages = r_pages + PCW'(1);
                    n_state = S_TAKE;
                end else begin
                    n_st    = ST_NO_MEMORY;
                    n_state = S_DONE;
                end
            end
            // split off the remainder when it can hold a header
            S_TAKE: begin
                n_addr   = byte_addr[14:0];
                n_fix_en = 1'b0;
                if ({2'b00, r_cs} > {2'b00, r_rg} + HG_W) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = gaddr(r_pg, SZW'(split_off));
                    o_mem_wdata = {1'b1, 1'b0, SZW'({2'b00, r_cs} - {2'b00, r_rg} - HG_W),
                                   r_off};
                    n_fix_off  = SZW'(cur_next);
                    n_fix_en   = (cur_next < PG_W);
                    n_fix_prev = SZW'(split_off);
                    n_cs       = r_rg;
                end
                n_state = S_TCUR;
            end
            S_TCUR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = {1'b1, 1'b1, r_cs, r_cp};
                n_cu        = 1'b1;
                n_ret       = S_DONE;
                n_state     = r_fix_en ? S_FIXRD : S_DONE;
            end
            // re-link the previous pointer of a following entry
            S_FIXRD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = gaddr(r_pg, r_fix_off);
                n_state     = S_FIXWR;
            end
            S_FIXWR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = gaddr(r_pg, r_fix_off);
                o_mem_wdata = {i_mem_rdata[EW-1:SZW], r_fix_prev};
                n_state     = r_ret;
            end
            // free: address checks
            S_FCHK: begin
                if (32'(r_fa) < 32'(HEADER_BYTES) || fa_rel[2:0] != 3'd0 ||
                    fa_rel >= 32'(POOL) || fa_page >= r_pages) begin
                    n_state = S_DONE;
                end else begin
                    n_pg    = fa_page;
                    n_g     = GW'(fa_rel >> 3);
                    n_state = S_FOFF;
                end
            end
            S_FOFF: begin
                n_off   = SZW'(32'(r_g) - 32'(r_pg) * 32'(PG));
                n_state = S_FRD;
            end
            S_FRD: begin
                o_mem_re = 1'b1;
                n_state  = S_FCUR;
            end
            S_FCUR: begin
                if (!m_v || !m_u) begin
                    n_state = S_DONE;
                end else begin
                    n_cv = 1'b1;
                    n_cu = 1'b0;
                    n_cs = m_s;
                    n_cp = m_p;
                    if (r_off != '0) begin
                        o_mem_re    = 1'b1;
                        o_mem_raddr = gaddr(r_pg, m_p);
                        n_state     = S_FPRV;
                    end else begin
                        n_state = S_FNX;
                    end
                end
            end
            // merge into a free previous entry
            S_FPRV: begin
                if (!m_u) begin
                    o_mem_we    = 1'b1;
                    o_mem_wdata = {1'b0, 1'b0, r_cs, r_cp};
                    n_fix_off   = SZW'(cur_next);
                    n_fix_en    = (cur_next < PG_W);
                    n_fix_prev  = r_cp;
                    n_cs        = SZW'({2'b00, m_s} + HG_W + {2'b00, r_cs});
                    n_off       = r_cp;
                    n_cp        = m_p;
                    n_cu        = 1'b0;
                    n_cv        = 1'b1;
                    n_ret       = S_FNX;
                    n_state     = (cur_next < PG_W) ? S_FIXRD : S_FNX;
                end else begin
                    n_state = S_FNX;
                end
            end
            S_FNX: begin
                if (cur_next < PG_W) begin
                    n_noff      = SZW'(cur_next);
                    o_mem_re    = 1'b1;
                    o_mem_raddr = gaddr(r_pg, SZW'(cur_next));
                    n_state     = S_FNCHK;
                end else begin
                    n_state = S_FEND;
                end
            end
            // merge a free following entry
            S_FNCHK: begin
                if (!m_u) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = gaddr(r_pg, r_noff);
                    o_mem_wdata = {1'b0, 1'b0, m_s, m_p};
                    n_cs        = SZW'({2'b00, r_cs} + HG_W + {2'b00, m_s});
                    n_fix_off   = SZW'(rd_next);
                    n_fix_en    = (rd_next < PG_W);
                    n_fix_prev  = r_off;
                    n_ret       = S_FEND;
                    n_state     = (rd_next < PG_W) ? S_FIXRD : S_FEND;
                end else begin
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                o_mem_we = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                o_done.valid = 1'b1;
                if (i_done_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_pages <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_pages <= n_pages;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_pg       <= n_pg;
        r_off      <= n_off;
        r_rg       <= n_rg;
        r_noff     <= n_noff;
        r_fix_off  <= n_fix_off;
        r_fix_prev <= n_fix_prev;
        r_fix_en   <= n_fix_en;
        r_cv       <= n_cv;
        r_cu       <= n_cu;
        r_cs       <= n_cs;
        r_cp       <= n_cp;
        r_fa       <= n_fa;
        r_g        <= n_g;
        r_st       <= n_st;
        r_addr     <= n_addr;
    end

`ifndef SYNTHESIS
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_mem_we && o_mem_re))
        else $error("header store read and written in one cycle");
    a_pages_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pages) <= 32'(NUM_PAGES))
        else $error("opened page count beyond pool");
    a_pages_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_pages >= $past(r_pages))
        else $error("opened page count went down");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_done_ready) |=> r_state == S_IDLE)
        else $error("result handed over without returning to idle");
`endif

endmodule
`default_nettype wire

[src/first_fit_heap_allocator_unit.sv]
// Top level of the first-fit heap allocator: sequencer, header store, result register.
//
//   channel | direction | handshake                 | beat
//   req     | in        | i_req_valid / o_req_stall | t_req
//   res     | out       | o_res_valid / i_res_stall | t_res
//
// One request is worked on at a time; a result may wait in the output register
// while the next request is taken. Size errors and null frees go straight to the
// result and a rejected free ends after its checks; an allocate walks the headers
// in turn and a free reads, merges and re-links headers, all through the header
// store, which the sequencer uses for one read or one write per cycle.
// Synchronous active-low reset empties the pool; the store needs no clearing pass.
// A stalled result holds the output register; the sequencer then waits in its last state.
`default_nettype none
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int PAGE_BYTES   = 4096,
    parameter int NUM_PAGES    = 8,
    parameter int HEADER_BYTES = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire t_req i_req,
    output logic      o_req_stall,
    output logic      o_res_valid,
    output t_res      o_res,
    input  wire logic i_res_stall
);

    localparam int PG  = PAGE_BYTES / 8;
    localparam int GR  = NUM_PAGES * PG;
    localparam int GW  = $clog2(GR);
    localparam int SZW = $clog2(PG);
    localparam int EW  = 2 + 2 * SZW;

    t_done         done;
    logic          done_ready;
    logic          mem_we, mem_re;
    logic [GW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic          r_res_valid;
    t_res          r_res;

    ffha_ctrl #(
        .PAGE_BYTES   (PAGE_BYTES),
        .NUM_PAGES    (NUM_PAGES),
        .HEADER_BYTES (HEADER_BYTES),
        .GW           (GW),
        .SZW          (SZW),
        .EW           (EW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req        (i_req),
        .o_req_stall  (o_req_stall),
        .o_done       (done),
        .i_done_ready (done_ready),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_re     (mem_re),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    ffha_hdr_mem #(
        .DEPTH (GR),
        .AW    (GW),
        .DW    (EW)
    ) u_hdr_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // output register: free when empty or being taken
    assign done_ready = !r_res_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (done_ready) begin
            r_res_valid <= done.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done_ready && done.valid) begin
            r_res <= done.res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
`default_nettype wire
